// File: rtl/core/conv2d_bias_activation_macros.svh
// assertion macros shared by the conv2d block
`ifndef CONV2D_BIAS_ACTIVATION_MACROS_SVH
`define CONV2D_BIAS_ACTIVATION_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("conv2d check failed");
// next-cycle implication
`define CBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("conv2d check failed");
`else
`define CBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/cba_pkg.sv
package cba_pkg;

    localparam int GROUP_W  = 5;
    localparam int GROUPS   = 1 << GROUP_W;
    localparam int IDX_MAX  = 63;
    localparam int STEP_MAX = 15;
    localparam int Q_ONE    = 65536;
    localparam int Q_SIX    = 393216;

    typedef enum logic [1:0] {
        FUNC_FEATURE = 2'd0,
        FUNC_WEIGHT  = 2'd1,
        FUNC_BIAS    = 2'd2,
        FUNC_COMPUTE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELU  = 2'd1,
        ACT_CLAMP = 2'd2,
        ACT_RELU6 = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        REG_STRIDE_ROWS   = 3'd0,
        REG_STRIDE_COLS   = 3'd1,
        REG_DILATION_ROWS = 3'd2,
        REG_DILATION_COLS = 3'd3,
        REG_PAD_TOP       = 3'd4,
        REG_PAD_LEFT      = 3'd5,
        REG_GROUP_COUNT   = 3'd6,
        REG_ACTIVATION    = 3'd7
    } t_reg;

    typedef struct packed {
        t_func              func;
        logic [3:0]         first_channel;
        logic [3:0]         second_channel;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               saturated;
    } t_result;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cba_ram.sv
module cba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/conv2d_bias_activation.sv
// Grouped 2-D convolution with bias and activation. Load words (feature, weight, bias) are
// written in the cycle they are accepted and never raise busy. A compute word for an output
// channel below OUT_CHANNELS raises busy through S_GROUP (the group base is found one group
// at a time), S_RUN (every kernel tap of the in_per input channels of its group, in_per being
// the input channel count of one group), S_DRAIN, S_DRAIN2 and S_FINISH. The rate is set by
// the single read port of the feature and weight memories: one kernel tap per cycle, taps
// outside the image included. The result is held on o_result and marked by o_done, high for
// exactly one cycle, in the first cycle busy is low again; it cannot be held off, so the
// receiver must take it then. A new word may be started in that same cycle. A compute word
// for a channel at or above OUT_CHANNELS is dropped without a result. Configuration is to be
// written only while the block is idle; the block itself does not enforce this.
`include "conv2d_bias_activation_macros.svh"

module conv2d_bias_activation #(
    parameter int IN_CHANNELS   = 16,
    parameter int OUT_CHANNELS  = 16,
    parameter int IMAGE_HEIGHT  = 32,
    parameter int IMAGE_WIDTH   = 32,
    parameter int KERNEL_HEIGHT = 3,
    parameter int KERNEL_WIDTH  = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cba_pkg::t_cmd     i_cmd,
    output logic              o_done,
    output cba_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import cba_pkg::*;

    localparam int FEAT_DEPTH = IN_CHANNELS * IMAGE_HEIGHT * IMAGE_WIDTH;
    localparam int WPC        = IN_CHANNELS * KERNEL_HEIGHT * KERNEL_WIDTH;
    localparam int WGT_DEPTH  = OUT_CHANNELS * WPC;
    localparam int FAW        = FEAT_DEPTH > 1 ? $clog2(FEAT_DEPTH) : 1;
    localparam int WAW        = WGT_DEPTH > 1 ? $clog2(WGT_DEPTH) : 1;
    localparam int BAW        = OUT_CHANNELS > 1 ? $clog2(OUT_CHANNELS) : 1;
    localparam int KHW        = KERNEL_HEIGHT > 1 ? $clog2(KERNEL_HEIGHT) : 1;
    localparam int KWW        = KERNEL_WIDTH > 1 ? $clog2(KERNEL_WIDTH) : 1;
    localparam int KCW        = $clog2(IN_CHANNELS + 1);
    localparam int OPW        = $clog2(OUT_CHANNELS + 1);
    localparam int IRW = $clog2(IDX_MAX * STEP_MAX + (KERNEL_HEIGHT - 1) * STEP_MAX
                                + STEP_MAX + 1) + 1;
    localparam int ICW = $clog2(IDX_MAX * STEP_MAX + (KERNEL_WIDTH - 1) * STEP_MAX
                                + STEP_MAX + 1) + 1;
    localparam int ACC_W      = 32 + $clog2(WPC + 1) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROUP,
        S_RUN,
        S_DRAIN,
        S_DRAIN2,
        S_FINISH
    } t_state;

    // configuration
    logic [3:0]         r_stride_rows;
    logic [3:0]         r_stride_cols;
    logic [3:0]         r_dil_rows;
    logic [3:0]         r_dil_cols;
    logic [3:0]         r_pad_top;
    logic [3:0]         r_pad_left;
    logic [GROUP_W-1:0] r_group_count;
    t_act               r_act_mode;

    // control and datapath
    t_state                   r_state;
    logic                     r_done;
    t_result                  r_result;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_bias_take;
    logic [OUT_CHANNELS-1:0]  r_bias_vld;
    logic [BAW-1:0]           r_ch;
    logic [3:0]               r_rem;
    logic [KCW-1:0]           r_chan;
    logic [KCW-1:0]           r_k;
    logic [KCW-1:0]           r_in_per;
    logic [OPW-1:0]           r_out_per;
    logic [KHW-1:0]           r_kh;
    logic [KWW-1:0]           r_kw;
    logic signed [IRW-1:0]    r_ir0;
    logic signed [IRW-1:0]    r_ir;
    logic signed [ICW-1:0]    r_ic0;
    logic signed [ICW-1:0]    r_ic;
    logic [WAW-1:0]           r_waddr;
    logic signed [31:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic [KCW-1:0] w_in_per_tab  [GROUPS];
    logic [OPW-1:0] w_out_per_tab [GROUPS];

    logic                    w_accept;
    logic                    w_go;
    logic                    w_feat_we;
    logic                    w_wgt_we;
    logic                    w_bias_we;
    logic [FAW-1:0]          w_feat_waddr;
    logic [WAW-1:0]          w_wgt_waddr;
    logic [BAW-1:0]          w_bias_addr;
    logic [15:0]             w_load16;
    logic [FAW-1:0]          w_feat_raddr;
    logic [15:0]             w_feat_rdata;
    logic [15:0]             w_wgt_rdata;
    logic [31:0]             w_bias_rdata;
    logic                    w_tap_ok;
    logic signed [IRW-1:0]   w_ir0;
    logic signed [ICW-1:0]   w_ic0;
    logic signed [ACC_W-1:0] w_act;
    logic                    w_ovf;
    logic signed [31:0]      w_res;

    // per group count: channels per group, bad counts fall back to one group
    for (genvar gi = 0; gi < GROUPS; gi++) begin : g_grp
        localparam int GD = (gi == 0) ? 1 : gi;
        localparam bit OK = (gi != 0) && (IN_CHANNELS % GD == 0)
                            && (OUT_CHANNELS % GD == 0);
        assign w_in_per_tab[gi]  = KCW'(OK ? IN_CHANNELS / GD : IN_CHANNELS);
        assign w_out_per_tab[gi] = OPW'(OK ? OUT_CHANNELS / GD : OUT_CHANNELS);
    end

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_go     = w_accept && (i_cmd.func == FUNC_COMPUTE)
                      && (int'(i_cmd.first_channel) < OUT_CHANNELS);

    assign w_feat_we = w_accept && (i_cmd.func == FUNC_FEATURE)
                       && (int'(i_cmd.first_channel) < IN_CHANNELS)
                       && (int'(i_cmd.row_index) < IMAGE_HEIGHT)
                       && (int'(i_cmd.col_index) < IMAGE_WIDTH);
    assign w_wgt_we  = w_accept && (i_cmd.func == FUNC_WEIGHT)
                       && (int'(i_cmd.first_channel) < OUT_CHANNELS)
                       && (int'(i_cmd.second_channel) < IN_CHANNELS)
                       && (int'(i_cmd.row_index) < KERNEL_HEIGHT)
                       && (int'(i_cmd.col_index) < KERNEL_WIDTH);
    assign w_bias_we = w_accept && (i_cmd.func == FUNC_BIAS)
                       && (int'(i_cmd.first_channel) < OUT_CHANNELS);

    assign w_feat_waddr = (FAW'(i_cmd.first_channel) * FAW'(IMAGE_HEIGHT)
                           + FAW'(i_cmd.row_index)) * FAW'(IMAGE_WIDTH)
                          + FAW'(i_cmd.col_index);
    assign w_wgt_waddr  = ((WAW'(i_cmd.first_channel) * WAW'(IN_CHANNELS)
                            + WAW'(i_cmd.second_channel)) * WAW'(KERNEL_HEIGHT)
                           + WAW'(i_cmd.row_index)) * WAW'(KERNEL_WIDTH)
                          + WAW'(i_cmd.col_index);
    assign w_bias_addr  = BAW'(i_cmd.first_channel);
    assign w_load16     = sat16(i_cmd.value);

    // first tap position of the window, may be negative under padding
    assign w_ir0 = $signed(IRW'(i_cmd.row_index) * IRW'(r_stride_rows) - IRW'(r_pad_top));
    assign w_ic0 = $signed(ICW'(i_cmd.col_index) * ICW'(r_stride_cols) - ICW'(r_pad_left));

    assign w_tap_ok = (r_ir >= 0) && (int'(r_ir) < IMAGE_HEIGHT)
                      && (r_ic >= 0) && (int'(r_ic) < IMAGE_WIDTH);
    assign w_feat_raddr = (FAW'(r_chan) * FAW'(IMAGE_HEIGHT) + FAW'($unsigned(r_ir)))
                          * FAW'(IMAGE_WIDTH) + FAW'($unsigned(r_ic));

    cba_ram #(
        .WIDTH (16),
        .DEPTH (FEAT_DEPTH)
    ) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (w_feat_we),
        .i_waddr (w_feat_waddr),
        .i_wdata (w_load16),
        .i_raddr (w_feat_raddr),
        .o_rdata (w_feat_rdata)
    );

    cba_ram #(
        .WIDTH (16),
        .DEPTH (WGT_DEPTH)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (w_wgt_waddr),
        .i_wdata (w_load16),
        .i_raddr (r_waddr),
        .o_rdata (w_wgt_rdata)
    );

    cba_ram #(
        .WIDTH (32),
        .DEPTH (OUT_CHANNELS)
    ) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_bias_we),
        .i_waddr (w_bias_addr),
        .i_wdata (i_cmd.value),
        .i_raddr (w_bias_addr),
        .o_rdata (w_bias_rdata)
    );

    // activation on the exact sum, then clip to 32 bits
    always_comb begin
        w_act = r_acc;
        unique case (r_act_mode)
            ACT_NONE: begin
                w_act = r_acc;
            end
            ACT_RELU: begin
                if (r_acc < 0) w_act = '0;
            end
            ACT_CLAMP: begin
                if (r_acc > ACC_W'(Q_ONE)) begin
                    w_act = ACC_W'(Q_ONE);
                end else if (r_acc < ACC_W'(-Q_ONE)) begin
                    w_act = ACC_W'(-Q_ONE);
                end
            end
            ACT_RELU6: begin
                if (r_acc < 0) begin
                    w_act = '0;
                end else if (r_acc > ACC_W'(Q_SIX)) begin
                    w_act = ACC_W'(Q_SIX);
                end
            end
            default: begin
                w_act = r_acc;
            end
        endcase
        w_ovf = (w_act[ACC_W-1:31] != {(ACC_W - 31){w_act[ACC_W-1]}});
        if (!w_ovf) begin
            w_res = w_act[31:0];
        end else if (w_act[ACC_W-1]) begin
            w_res = 32'sh8000_0000;
        end else begin
            w_res = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_bias_take <= 1'b0;
            r_bias_vld  <= '0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= r_v1;
            r_prod <= $signed(w_feat_rdata) * $signed(w_wgt_rdata);
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (w_bias_we) begin
                r_bias_vld[w_bias_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_go) begin
                        r_state     <= S_GROUP;
                        r_bias_take <= 1'b1;
                        r_ch        <= w_bias_addr;
                        r_rem       <= i_cmd.first_channel;
                        r_chan      <= '0;
                        r_k         <= '0;
                        r_kh        <= '0;
                        r_kw        <= '0;
                        r_in_per    <= w_in_per_tab[r_group_count];
                        r_out_per   <= w_out_per_tab[r_group_count];
                        r_ir0       <= w_ir0;
                        r_ir        <= w_ir0;
                        r_ic0       <= w_ic0;
                        r_ic        <= w_ic0;
                        r_waddr     <= WAW'(i_cmd.first_channel) * WAW'(WPC);
                    end
                end
                S_GROUP: begin
                    // bias word arrives in the cycle after the accept
                    r_bias_take <= 1'b0;
                    if (r_bias_take) begin
                        r_acc <= r_bias_vld[r_ch] ? ACC_W'($signed(w_bias_rdata)) : '0;
                    end
                    // group base: step down the channel one group at a time
                    if (OPW'(r_rem) >= r_out_per) begin
                        r_rem  <= r_rem - 4'(r_out_per);
                        r_chan <= r_chan + r_in_per;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_v1    <= w_tap_ok;
                    r_waddr <= r_waddr + 1'b1;
                    if (r_kw == KWW'(KERNEL_WIDTH - 1)) begin
                        r_kw <= '0;
                        r_ic <= r_ic0;
                        if (r_kh == KHW'(KERNEL_HEIGHT - 1)) begin
                            r_kh   <= '0;
                            r_ir   <= r_ir0;
                            r_k    <= r_k + 1'b1;
                            r_chan <= r_chan + 1'b1;
                            if (r_k == r_in_per - 1'b1) begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_kh <= r_kh + 1'b1;
                            r_ir <= r_ir + $signed(IRW'(r_dil_rows));
                        end
                    end else begin
                        r_kw <= r_kw + 1'b1;
                        r_ic <= r_ic + $signed(ICW'(r_dil_cols));
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DRAIN2;
                end
                S_DRAIN2: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_result.result_value <= w_res;
                    r_result.saturated    <= w_ovf;
                    r_done                <= 1'b1;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_rows <= 4'd1;
            r_stride_cols <= 4'd1;
            r_dil_rows    <= 4'd1;
            r_dil_cols    <= 4'd1;
            r_pad_top     <= 4'd0;
            r_pad_left    <= 4'd0;
            r_group_count <= GROUP_W'(1);
            r_act_mode    <= ACT_NONE;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg'(paddr[4:2]))
                REG_STRIDE_ROWS:   r_stride_rows <= pwdata[3:0];
                REG_STRIDE_COLS:   r_stride_cols <= pwdata[3:0];
                REG_DILATION_ROWS: r_dil_rows    <= pwdata[3:0];
                REG_DILATION_COLS: r_dil_cols    <= pwdata[3:0];
                REG_PAD_TOP:       r_pad_top     <= pwdata[3:0];
                REG_PAD_LEFT:      r_pad_left    <= pwdata[3:0];
                REG_GROUP_COUNT:   r_group_count <= pwdata[GROUP_W-1:0];
                REG_ACTIVATION:    r_act_mode    <= t_act'(pwdata[1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[4:2]))
            REG_STRIDE_ROWS:   prdata = 32'(r_stride_rows);
            REG_STRIDE_COLS:   prdata = 32'(r_stride_cols);
            REG_DILATION_ROWS: prdata = 32'(r_dil_rows);
            REG_DILATION_COLS: prdata = 32'(r_dil_cols);
            REG_PAD_TOP:       prdata = 32'(r_pad_top);
            REG_PAD_LEFT:      prdata = 32'(r_pad_left);
            REG_GROUP_COUNT:   prdata = 32'(r_group_count);
            REG_ACTIVATION:    prdata = 32'(r_act_mode);
            default:           prdata = '0;
        endcase
    end

    `CBA_ASSERT_IMP(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)
    `CBA_ASSERT_IMP(a_done_after_finish, i_clk, i_rst_n, o_done, $past(r_state == S_FINISH))
    `CBA_ASSERT_IMP(a_busy_ends_in_result, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_done)
    `CBA_ASSERT_NXT(a_load_stays_idle, i_clk, i_rst_n, w_accept && !w_go, !busy)
    `CBA_ASSERT_IMP(a_acc_in_window, i_clk, i_rst_n, r_v2, (r_state == S_RUN) || (r_state == S_DRAIN) || (r_state == S_DRAIN2))

endmodule
